// ===== sv/leb_pkg.sv =====
// Shared constants, control types and the dispatch map of the line editor buffer.
package leb_pkg;

  localparam int LINE_DEPTH = 64;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [BYTE_W-1:0] NUL_BYTE     = 8'd0;
  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;
  localparam logic [BYTE_W-1:0] SPACE_BYTE   = 8'd32;

  localparam logic [BYTE_W-1:0] ERASE_RST     = 8'd42;
  localparam logic [BYTE_W-1:0] ALT_EOL_RST   = 8'd64;
  localparam logic [BYTE_W-1:0] KILL_WORD_RST = 8'd36;
  localparam logic [BYTE_W-1:0] KILL_LINE_RST = 8'd38;

  localparam logic [CFG_IDX_W-1:0] REG_ERASE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_EOL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KILL_WORD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KILL_LINE = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_ERASE    = 4'd1,
    ST_KLINE    = 4'd2,
    ST_ORD      = 4'd3,
    ST_EOL      = 4'd4,
    ST_EOL_WAIT = 4'd5,
    ST_EMIT     = 4'd6,
    ST_EOL_DONE = 4'd7,
    ST_KW_INIT  = 4'd8,
    ST_KW_CHK   = 4'd9,
    ST_KW_SP    = 4'd10,
    ST_KW_WORD  = 4'd11,
    ST_KW_DONE  = 4'd12
  } step_t;

  typedef enum logic [2:0] {
    CLS_DROP,
    CLS_ERASE,
    CLS_EOL,
    CLS_KWORD,
    CLS_KLINE,
    CLS_ORD
  } byte_class_t;

  typedef enum logic [2:0] {
    FILL_HOLD,
    FILL_INC,
    FILL_DEC,
    FILL_CLEAR,
    FILL_LOAD_PTR
  } fill_op_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_LOAD_FILL,
    PTR_DEC,
    PTR_INC
  } ptr_op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_FILL_ZERO,
    C_FILL_FULL,
    C_AT_LAST,
    C_PTR_ZERO,
    C_RD_SPACE,
    C_WORD_DONE
  } cond_t;

  typedef enum logic {
    W_NONE,
    W_OUT_BUSY
  } wait_t;

  typedef enum logic [1:0] {
    ON_ALWAYS,
    ON_TRUE,
    ON_FALSE
  } when_t;

  typedef struct packed {
    logic     in_ready;
    logic     in_load;
    logic     ram_we;
    logic     wr_newline;
    logic     addr_minus;
    logic     emit;
    fill_op_t fill_op;
    ptr_op_t  ptr_op;
    wait_t    wait_sel;
    cond_t    cond;
    when_t    when;
    logic     dispatch;
    step_t    jt;
    step_t    jf;
  } uword_t;

  typedef struct packed {
    logic     in_ready;
    logic     in_load;
    logic     ram_we;
    logic     wr_newline;
    logic     addr_minus;
    logic     emit;
    fill_op_t fill_op;
    ptr_op_t  ptr_op;
  } ctrl_t;

  typedef struct packed {
    logic        in_valid;
    byte_class_t cls;
    logic        fill_zero;
    logic        fill_full;
    logic        at_last;
    logic        ptr_zero;
    logic        rd_space;
    logic        out_busy;
  } stat_t;

  function automatic step_t leb_dispatch(byte_class_t cls);
    step_t s;
    case (cls)
      CLS_ERASE: s = ST_ERASE;
      CLS_EOL:   s = ST_EOL;
      CLS_KWORD: s = ST_KW_INIT;
      CLS_KLINE: s = ST_KLINE;
      CLS_ORD:   s = ST_ORD;
      default:   s = ST_IDLE;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/leb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module leb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/leb_seq.sv =====
// Microcode store, step counter and branch logic of the line editor buffer.
module leb_seq (
  input  logic           clk,
  input  logic           rst,
  input  leb_pkg::stat_t stat,
  output leb_pkg::ctrl_t ctrl
);

  function automatic leb_pkg::uword_t ucode(leb_pkg::step_t s);
    leb_pkg::uword_t w;
    w = '{in_ready: 1'b0, in_load: 1'b0, ram_we: 1'b0, wr_newline: 1'b0,
          addr_minus: 1'b0, emit: 1'b0, fill_op: leb_pkg::FILL_HOLD,
          ptr_op: leb_pkg::PTR_HOLD, wait_sel: leb_pkg::W_NONE,
          cond: leb_pkg::C_ALWAYS, when: leb_pkg::ON_ALWAYS, dispatch: 1'b0,
          jt: leb_pkg::ST_IDLE, jf: leb_pkg::ST_IDLE};
    case (s)
      leb_pkg::ST_IDLE: begin
        w.in_ready = 1'b1;
        w.in_load  = 1'b1;
        w.cond     = leb_pkg::C_ACCEPT;
        w.when     = leb_pkg::ON_TRUE;
        w.dispatch = 1'b1;
      end
      leb_pkg::ST_ERASE: begin
        w.cond    = leb_pkg::C_FILL_ZERO;
        w.when    = leb_pkg::ON_FALSE;
        w.fill_op = leb_pkg::FILL_DEC;
      end
      leb_pkg::ST_KLINE: begin
        w.fill_op = leb_pkg::FILL_CLEAR;
      end
      leb_pkg::ST_ORD: begin
        w.cond    = leb_pkg::C_FILL_FULL;
        w.when    = leb_pkg::ON_FALSE;
        w.ram_we  = 1'b1;
        w.fill_op = leb_pkg::FILL_INC;
      end
      leb_pkg::ST_EOL: begin
        w.ram_we     = 1'b1;
        w.wr_newline = 1'b1;
        w.ptr_op     = leb_pkg::PTR_ZERO;
        w.jt         = leb_pkg::ST_EOL_WAIT;
      end
      leb_pkg::ST_EOL_WAIT: begin
        w.jt = leb_pkg::ST_EMIT;
      end
      leb_pkg::ST_EMIT: begin
        w.wait_sel = leb_pkg::W_OUT_BUSY;
        w.emit     = 1'b1;
        w.ptr_op   = leb_pkg::PTR_INC;
        w.cond     = leb_pkg::C_AT_LAST;
        w.jt       = leb_pkg::ST_EOL_DONE;
        w.jf       = leb_pkg::ST_EMIT;
      end
      leb_pkg::ST_EOL_DONE: begin
        w.fill_op = leb_pkg::FILL_CLEAR;
      end
      leb_pkg::ST_KW_INIT: begin
        w.addr_minus = 1'b1;
        w.ptr_op     = leb_pkg::PTR_LOAD_FILL;
        w.jt         = leb_pkg::ST_KW_CHK;
      end
      leb_pkg::ST_KW_CHK: begin
        w.addr_minus = 1'b1;
        w.cond       = leb_pkg::C_PTR_ZERO;
        w.jt         = leb_pkg::ST_IDLE;
        w.jf         = leb_pkg::ST_KW_SP;
      end
      leb_pkg::ST_KW_SP: begin
        w.addr_minus = 1'b1;
        w.cond       = leb_pkg::C_RD_SPACE;
        w.when       = leb_pkg::ON_TRUE;
        w.ptr_op     = leb_pkg::PTR_DEC;
        w.jt         = leb_pkg::ST_KW_CHK;
        w.jf         = leb_pkg::ST_KW_WORD;
      end
      leb_pkg::ST_KW_WORD: begin
        w.addr_minus = 1'b1;
        w.cond       = leb_pkg::C_WORD_DONE;
        w.when       = leb_pkg::ON_FALSE;
        w.ptr_op     = leb_pkg::PTR_DEC;
        w.jt         = leb_pkg::ST_KW_DONE;
        w.jf         = leb_pkg::ST_KW_WORD;
      end
      leb_pkg::ST_KW_DONE: begin
        w.fill_op = leb_pkg::FILL_LOAD_PTR;
      end
      default: begin
        w.jt = leb_pkg::ST_IDLE;
      end
    endcase
    return w;
  endfunction

  leb_pkg::step_t  step;
  leb_pkg::step_t  step_next;
  leb_pkg::uword_t w;
  logic            busy;
  logic            c;
  logic            run;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= leb_pkg::ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    w    = ucode(step);
    busy = (w.wait_sel == leb_pkg::W_OUT_BUSY) && stat.out_busy;
    case (w.cond)
      leb_pkg::C_ALWAYS:    c = 1'b1;
      leb_pkg::C_ACCEPT:    c = stat.in_valid && w.in_ready;
      leb_pkg::C_FILL_ZERO: c = stat.fill_zero;
      leb_pkg::C_FILL_FULL: c = stat.fill_full;
      leb_pkg::C_AT_LAST:   c = stat.at_last;
      leb_pkg::C_PTR_ZERO:  c = stat.ptr_zero;
      leb_pkg::C_RD_SPACE:  c = stat.rd_space;
      leb_pkg::C_WORD_DONE: c = stat.ptr_zero || stat.rd_space;
      default:              c = 1'b0;
    endcase
    case (w.when)
      leb_pkg::ON_ALWAYS: run = !busy;
      leb_pkg::ON_TRUE:   run = !busy && c;
      leb_pkg::ON_FALSE:  run = !busy && !c;
      default:            run = 1'b0;
    endcase

    ctrl.in_ready   = w.in_ready;
    ctrl.in_load    = w.in_load && run;
    ctrl.ram_we     = w.ram_we && run;
    ctrl.wr_newline = w.wr_newline;
    ctrl.addr_minus = w.addr_minus;
    ctrl.emit       = w.emit && run;
    ctrl.fill_op    = run ? w.fill_op : leb_pkg::FILL_HOLD;
    ctrl.ptr_op     = run ? w.ptr_op : leb_pkg::PTR_HOLD;

    if (busy) begin
      step_next = step;
    end else if (c) begin
      step_next = w.dispatch ? leb_pkg::leb_dispatch(stat.cls) : w.jt;
    end else begin
      step_next = w.jf;
    end
  end

endmodule

// ===== sv/leb_dp.sv =====
// Datapath of the line editor buffer: control registers, line store, pointers, output register.
module leb_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  leb_pkg::ctrl_t               ctrl,
  output leb_pkg::stat_t               stat,
  input  logic                         cfg_we,
  input  logic [leb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [leb_pkg::BYTE_W-1:0]   cfg_data,
  input  logic                         in_valid,
  input  logic [leb_pkg::BYTE_W-1:0]   in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [leb_pkg::BYTE_W-1:0]   out_data,
  output logic                         out_last
);

  logic [leb_pkg::BYTE_W-1:0] erase_char;
  logic [leb_pkg::BYTE_W-1:0] alt_eol_char;
  logic [leb_pkg::BYTE_W-1:0] kill_word_char;
  logic [leb_pkg::BYTE_W-1:0] kill_line_char;
  logic [leb_pkg::BYTE_W-1:0] in_byte;
  logic [leb_pkg::ADDR_W-1:0] fill;
  logic [leb_pkg::ADDR_W-1:0] fill_next;
  logic [leb_pkg::ADDR_W-1:0] ptr;
  logic [leb_pkg::ADDR_W-1:0] ptr_next;
  logic [leb_pkg::ADDR_W-1:0] rd_addr;
  logic [leb_pkg::BYTE_W-1:0] wr_data;
  logic [leb_pkg::BYTE_W-1:0] rd_data;
  leb_pkg::byte_class_t       cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      erase_char     <= leb_pkg::ERASE_RST;
      alt_eol_char   <= leb_pkg::ALT_EOL_RST;
      kill_word_char <= leb_pkg::KILL_WORD_RST;
      kill_line_char <= leb_pkg::KILL_LINE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        leb_pkg::REG_ERASE:     erase_char     <= cfg_data;
        leb_pkg::REG_ALT_EOL:   alt_eol_char   <= cfg_data;
        leb_pkg::REG_KILL_WORD: kill_word_char <= cfg_data;
        leb_pkg::REG_KILL_LINE: kill_line_char <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_data == leb_pkg::NUL_BYTE) begin
      cls = leb_pkg::CLS_DROP;
    end else if (in_data == erase_char) begin
      cls = leb_pkg::CLS_ERASE;
    end else if (in_data == alt_eol_char) begin
      cls = leb_pkg::CLS_EOL;
    end else if (in_data == kill_word_char) begin
      cls = leb_pkg::CLS_KWORD;
    end else if (in_data == kill_line_char) begin
      cls = leb_pkg::CLS_KLINE;
    end else if (in_data == leb_pkg::NEWLINE_BYTE) begin
      cls = leb_pkg::CLS_EOL;
    end else begin
      cls = leb_pkg::CLS_ORD;
    end
  end

  always_comb begin
    case (ctrl.fill_op)
      leb_pkg::FILL_INC:      fill_next = fill + leb_pkg::ADDR_W'(1);
      leb_pkg::FILL_DEC:      fill_next = fill - leb_pkg::ADDR_W'(1);
      leb_pkg::FILL_CLEAR:    fill_next = '0;
      leb_pkg::FILL_LOAD_PTR: fill_next = ptr;
      default:                fill_next = fill;
    endcase
    case (ctrl.ptr_op)
      leb_pkg::PTR_ZERO:      ptr_next = '0;
      leb_pkg::PTR_LOAD_FILL: ptr_next = fill;
      leb_pkg::PTR_DEC:       ptr_next = ptr - leb_pkg::ADDR_W'(1);
      leb_pkg::PTR_INC:       ptr_next = ptr + leb_pkg::ADDR_W'(1);
      default:                ptr_next = ptr;
    endcase
    rd_addr = ctrl.addr_minus ? ptr_next - leb_pkg::ADDR_W'(1) : ptr_next;
    wr_data = ctrl.wr_newline ? leb_pkg::NEWLINE_BYTE : in_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      ptr  <= '0;
    end else begin
      fill <= fill_next;
      ptr  <= ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.in_load) begin
      in_byte <= in_data;
    end
  end

  leb_ram #(
    .WIDTH (leb_pkg::BYTE_W),
    .DEPTH (leb_pkg::LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ctrl.ram_we),
    .waddr (fill),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_data <= rd_data;
      out_last <= (ptr == fill);
    end
  end

  always_comb begin
    stat.in_valid  = in_valid;
    stat.cls       = cls;
    stat.fill_zero = (fill == '0);
    stat.fill_full = (fill == leb_pkg::ADDR_W'(leb_pkg::LINE_DEPTH - 1));
    stat.at_last   = (ptr == fill);
    stat.ptr_zero  = (ptr == '0);
    stat.rd_space  = (rd_data == leb_pkg::SPACE_BYTE);
    stat.out_busy  = out_valid && !out_ready;
  end

endmodule

// ===== sv/line_editor_buffer_unit.sv =====
// Top level of the line editor buffer: microcoded sequencer driving the line datapath.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------
//  s_axis   | in        | tdata[7:0] = in_byte
//  m_axis   | out       | tdata[7:0] = out_byte, tlast = last
//  cfg      | in        | cfg_index selects register, cfg_data[7:0] value
//
// An input byte is taken only in the idle step. An end of line sends the stored line,
// newline included, one output byte per cycle from the line RAM read port while
// m_axis_tready keeps up. Reset sets the control registers to their defaults and
// empties the line; the line RAM is not cleared. A stalled output holds the emission
// step until m_axis_tready returns.
module line_editor_buffer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [leb_pkg::BYTE_W-1:0]    s_axis_tdata,   // [7:0] in_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [leb_pkg::BYTE_W-1:0]    m_axis_tdata,   // [7:0] out_byte
  output logic                          m_axis_tlast,
  input  logic                          cfg_we,
  input  logic [leb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [leb_pkg::BYTE_W-1:0]    cfg_data
);

  leb_pkg::ctrl_t ctrl;
  leb_pkg::stat_t stat;

  assign s_axis_tready = ctrl.in_ready;

  leb_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  leb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for line_editor_buffer_unit: directed table, then random edited lines.
module tb_top;
  import leb_pkg::*;

  typedef enum logic {
    ROW_BYTE,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [BYTE_W-1:0]     val;
    logic                  typed;
    logic [3:0]            nexp;
    logic [63:0]           exp;
  } stim_row_t;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              eol;
  } line_byte_t;

  localparam int STIM_ROWS = 33;
  localparam int SETTLE_CYCLES = 200;

  stim_row_t stim_tab [STIM_ROWS] = '{
    '{ROW_BYTE, '0, 8'h0A, 1'b1, 4'd1, "\n"},
    '{ROW_BYTE, '0, 8'h00, 1'b1, 4'd0, '0},
    '{ROW_BYTE, '0, "a",   1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, "b",   1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, "*",   1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, "@",   1'b1, 4'd2, "a\n"},
    '{ROW_BYTE, '0, "*",   1'b1, 4'd0, '0},
    '{ROW_BYTE, '0, "$",   1'b1, 4'd0, '0},
    '{ROW_BYTE, '0, " ",   1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, " ",   1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, "$",   1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, "x",   1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, " ",   1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, "y",   1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, "z",   1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, " ",   1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, "$",   1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, 8'h0A, 1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, "q",   1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, "&",   1'b1, 4'd0, '0},
    '{ROW_BYTE, '0, 8'hFF, 1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, 8'h01, 1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, 8'h80, 1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, 8'h0A, 1'b1, 4'd4, 64'hFF01800A},
    '{ROW_CFG, REG_ERASE,     8'h00, 1'b0, 4'd0, '0},
    '{ROW_CFG, REG_ALT_EOL,   8'hFF, 1'b0, 4'd0, '0},
    '{ROW_CFG, REG_KILL_WORD, 8'h0A, 1'b0, 4'd0, '0},
    '{ROW_CFG, REG_KILL_LINE, 8'hFF, 1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, "k",   1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, 8'h00, 1'b1, 4'd0, '0},
    '{ROW_BYTE, '0, 8'h0A, 1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, "m",   1'b0, 4'd0, '0},
    '{ROW_BYTE, '0, 8'hFF, 1'b1, 4'd2, "m\n"}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [BYTE_W-1:0]    s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [BYTE_W-1:0]    m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;

  logic [BYTE_W-1:0] line_model [LINE_DEPTH];
  int                line_fill = 0;
  logic [BYTE_W-1:0] erase_code = ERASE_RST;
  logic [BYTE_W-1:0] alt_eol_code = ALT_EOL_RST;
  logic [BYTE_W-1:0] kill_word_code = KILL_WORD_RST;
  logic [BYTE_W-1:0] kill_line_code = KILL_LINE_RST;

  line_byte_t pending_bytes [$];
  int         fail_count = 0;
  bit         feed_calm = 1'b0;

  line_editor_buffer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(20, 60);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_code();
    logic [BYTE_W-1:0] v;
    do v = BYTE_W'($urandom_range(1, 255)); while (v == NEWLINE_BYTE);
    return v;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return BYTE_W'($urandom_range("a", "z"));
    if (r < 55) return SPACE_BYTE;
    if (r < 62) return erase_code;
    if (r < 66) return kill_word_code;
    if (r < 68) return kill_line_code;
    if (r < 76) return NEWLINE_BYTE;
    if (r < 79) return alt_eol_code;
    if (r < 81) return NUL_BYTE;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Apply one accepted byte to the line model; queue the line when it ends and record is set.
  task automatic edit_line(input logic [BYTE_W-1:0] b, input bit record);
    int  n;
    int  i;
    bit  ends;
    ends = 1'b0;
    if (b == NUL_BYTE) begin
    end else if (b == erase_code) begin
      if (line_fill > 0) line_fill--;
    end else if (b == alt_eol_code) begin
      ends = 1'b1;
    end else if (b == kill_word_code) begin
      n = line_fill;
      while (n > 0 && line_model[n-1] == SPACE_BYTE) n--;
      if (n != 0) begin
        while (n > 0 && line_model[n-1] != SPACE_BYTE) n--;
        line_fill = n;
      end
    end else if (b == kill_line_code) begin
      line_fill = 0;
    end else if (b == NEWLINE_BYTE) begin
      ends = 1'b1;
    end else if (line_fill < LINE_DEPTH - 1) begin
      line_model[line_fill] = b;
      line_fill++;
    end
    if (ends) begin
      line_model[line_fill] = NEWLINE_BYTE;
      if (record) begin
        for (i = 0; i <= line_fill; i++) begin
          pending_bytes.push_back(line_byte_t'{line_model[i], i == line_fill});
        end
      end
      line_fill = 0;
    end
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int g;
    g = (feed_calm || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic feed_byte(input logic [BYTE_W-1:0] b);
    send_byte(b);
    edit_line(b, 1'b1);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_ERASE:     erase_code = val;
      REG_ALT_EOL:   alt_eol_code = val;
      REG_KILL_WORD: kill_word_code = val;
      REG_KILL_LINE: kill_line_code = val;
      default: ;
    endcase
  endtask

  // Hold the input until every queued line byte is out and the block is idle.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_output(input logic [BYTE_W-1:0] ch, input logic eol);
    line_byte_t want;
    if (pending_bytes.size() == 0) begin
      $display("%0t: unexpected output byte %02h last %0b", $time, ch, eol);
      fail_count++;
    end else begin
      want = pending_bytes.pop_front();
      if (want.ch !== ch) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.ch, ch);
        fail_count++;
      end
      if (want.eol !== eol) begin
        $display("%0t: last expected %0b actual %0b", $time, want.eol, eol);
        fail_count++;
      end
    end
  endtask

  initial begin : line_sink
    int   hold_left;
    int   taken;
    int   cyc;
    bit   calm;
    bit   long_done;
    logic nxt;
    hold_left = 0;
    taken     = 0;
    cyc       = 0;
    calm      = 1'b0;
    long_done = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        check_output(m_axis_tdata, m_axis_tlast);
        taken++;
      end
      if (cyc % 128 == 0) calm = ($urandom_range(0, 3) == 0);
      // hold off long enough that the block backs up into its input
      if (!long_done && taken >= 40 && m_axis_tvalid) begin
        long_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        nxt = 1'b1;
      end else begin
        hold_left = idle_len() - 1;
        nxt = 1'b0;
      end
      m_axis_tready <= nxt;
    end
  end

  initial begin : byte_feed
    int                i;
    int                k;
    int                p;
    stim_row_t         row;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] e;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] w;
    logic [BYTE_W-1:0] l;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < STIM_ROWS; i++) begin
      row = stim_tab[i];
      if (row.kind == ROW_CFG) begin
        if (i == 0 || stim_tab[i-1].kind != ROW_CFG) settle();
        write_reg(row.idx, row.val);
        if (i + 1 == STIM_ROWS || stim_tab[i+1].kind != ROW_CFG) cfg_we <= 1'b0;
      end else begin
        send_byte(row.val);
        edit_line(row.val, !row.typed);
        if (row.typed) begin
          for (k = 0; k < row.nexp; k++) begin
            pending_bytes.push_back(line_byte_t'{row.exp[8*(row.nexp-1-k) +: 8],
                                                 k == row.nexp - 1});
          end
        end
      end
    end

    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin
          e = ERASE_RST;
          a = ALT_EOL_RST;
          w = KILL_WORD_RST;
          l = KILL_LINE_RST;
        end
        1: begin
          e = 8'hFF;
          a = 8'h01;
          w = 8'h80;
          l = 8'h7F;
        end
        2: begin
          e = 8'h00;
          a = 8'h00;
          w = 8'h00;
          l = 8'h00;
        end
        default: begin
          e = rand_code();
          a = rand_code();
          w = rand_code();
          l = rand_code();
        end
      endcase
      settle();
      write_reg(REG_ERASE, e);
      write_reg(REG_ALT_EOL, a);
      write_reg(REG_KILL_WORD, w);
      write_reg(REG_KILL_LINE, l);
      cfg_we <= 1'b0;
      feed_calm = (p == 3);
      // overfill a line so ordinary bytes saturate one short of the depth
      if (p == 1 || p == 5) begin
        for (k = 0; k < LINE_DEPTH + 2; k++) begin
          do b = BYTE_W'($urandom_range(33, 126));
          while (b == erase_code || b == alt_eol_code || b == kill_word_code ||
                 b == kill_line_code);
          feed_byte(b);
        end
        feed_byte(NEWLINE_BYTE);
      end
      for (k = 0; k < 32; k++) begin
        feed_byte(pick_byte());
      end
      feed_byte(NEWLINE_BYTE);
    end

    settle();
    if (fail_count == 0) begin
      $display("PASS line_editor_buffer_unit");
    end else begin
      $display("FAIL line_editor_buffer_unit");
    end
    $finish;
  end

  initial begin : watchdog
    #120000000;
    $display("FAIL line_editor_buffer_unit");
    $finish;
  end

endmodule
